// ----- hw/rtl/hlz_pkg.sv -----
// shared types, constants and helpers of the huffman/lz stream decompressor
package hlz_pkg;

  localparam int NUM_SYMS    = 258;
  localparam int HEADER_LEN  = 264;
  localparam int MAGIC_LEN   = 6;
  localparam int SYM_W       = 9;
  localparam int CODE_W      = 16;
  localparam int SYM_END     = 256;
  localparam int MATCH_BIAS  = 3;
  localparam int LANES_MAX   = 8;
  localparam int CAP_W       = 32;

  localparam int DEF_OFFSET_BITS       = 12;
  localparam int DEF_MATCH_LENGTH_BITS = 8;
  localparam int DEF_MAX_CODE_LENGTH   = 16;
  localparam int DEF_OUTPUT_LANES      = 8;

  // bit positions inside the result tdata word
  localparam int TD_COUNT_LO = 64;
  localparam int TD_TOTAL_LO = 68;
  localparam int TD_W        = 104;

  typedef logic [2:0] status_t;
  localparam status_t STAT_DATA       = 3'd0;
  localparam status_t STAT_DONE       = 3'd1;
  localparam status_t STAT_BAD_HEADER = 3'd2;
  localparam status_t STAT_TRUNCATED  = 3'd3;
  localparam status_t STAT_BAD_CODE   = 3'd4;
  localparam status_t STAT_OFFSET     = 3'd5;
  localparam status_t STAT_CAPACITY   = 3'd6;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_SYMBOL,
    PH_MATCH,
    PH_TERMINAL
  } phase_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BD_RD,
    ST_BD_CHK,
    ST_BIT,
    ST_LK_RD,
    ST_LK_CMP,
    ST_CP_RD,
    ST_CP_WR,
    ST_EMIT,
    ST_NEXT,
    ST_ENDBYTE,
    ST_FINISH,
    ST_END
  } state_t;

  typedef struct packed {
    logic [LANES_MAX-1:0][7:0] lanes;
    logic [3:0]                count;
    status_t                   status;
    logic [CAP_W-1:0]          total;
  } res_t;

  // magic bytes followed by the little-endian symbol count
  function automatic logic [7:0] head_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h54;
      3'd1:    b = 8'h43;
      3'd2:    b = 8'h46;
      3'd3:    b = 8'h31;
      3'd4:    b = 8'h02;
      3'd5:    b = 8'h01;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ----- hw/rtl/huffman_lz_stream_decompressor.sv -----
// top level of the canonical huffman / lz77 stream decompressor
//
// the block takes one compressed byte per input transfer and is busy until every result
// caused by that byte has been handed to the output side. the last header byte starts
// a code build that walks all 258 stored code lengths for each code length. a bitstream
// byte takes eight bit steps and is then closed; a symbol step adds a scan of the sorted
// code table, and the scan resumes where the previous bit left off, so over one whole
// symbol it visits each entry once, plus one revisit per bit of the entry that stopped
// the scan. a match copies its bytes one at a time through the history ram read port.
// each result may also wait on m_axis_tready. results pass through a staging slot into
// the output register; the last result of a byte may still wait in the output register
// while the next input byte is taken. results carry up to eight decoded bytes; terminal
// status results carry none, and after one the block swallows further bytes until reset.
module huffman_lz_stream_decompressor
  import hlz_pkg::*;
#(
  parameter int OFFSET_BITS       = DEF_OFFSET_BITS,
  parameter int MATCH_LENGTH_BITS = DEF_MATCH_LENGTH_BITS,
  parameter int MAX_CODE_LENGTH   = DEF_MAX_CODE_LENGTH,
  parameter int OUTPUT_LANES      = DEF_OUTPUT_LANES
) (
  input  logic              clk,
  input  logic              rst,
  // configuration: output capacity
  input  logic              cfg_we,
  input  logic [CAP_W-1:0]  cfg_wdata,
  // compressed input
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,   // in_byte
  input  logic              s_axis_tlast,   // last_byte
  // decoded output
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [TD_W-1:0]   m_axis_tdata,   // lane0..lane7, byte_count, total_length
  output logic [2:0]        m_axis_tuser,   // status
  output logic              m_axis_tlast    // last_of_run
);

  localparam int HIST_DEPTH = 1 << OFFSET_BITS;
  localparam int FT         = OFFSET_BITS + MATCH_LENGTH_BITS;
  localparam int FCW        = $clog2(FT + 1);
  localparam int LEN_W      = MATCH_LENGTH_BITS + 2;
  localparam int CLW        = $clog2(MAX_CODE_LENGTH + 1);
  localparam int LW         = $clog2(OUTPUT_LANES + 1);
  localparam int ENT_W      = CLW + CODE_W + SYM_W;

  // sequencer
  state_t state, state_next, ret_state, ret_next;
  phase_t phase;

  // stream registers
  logic [SYM_W-1:0]  hdr_idx;
  logic [7:0]        byte_r;
  logic              last_r;
  logic [2:0]        bit_k;
  logic [CODE_W-1:0] partial;
  logic [CLW-1:0]    pbits;
  logic [SYM_W-1:0]  scan_idx, scan_start, used;
  logic [SYM_W-1:0]  bs;
  logic [CLW-1:0]    blen, prev;
  logic [CODE_W-1:0] code;
  logic [FT-1:0]     mf;
  logic [FCW-1:0]    mfc;
  logic [OFFSET_BITS:0] off_r;
  logic [LEN_W-1:0]  left;
  logic [CAP_W-1:0]  out_cnt, cap;
  logic [7:0]        lane_buf [OUTPUT_LANES];
  logic [LW-1:0]     fill;
  status_t           fin_status;

  // output staging slot and output register
  res_t stg, outr;
  logic stg_v, out_valid, out_last;

  // ram ports
  logic [7:0]             clen_rdata;
  logic [ENT_W-1:0]       ent_rdata, ent_wdata;
  logic [7:0]             hist_rdata;
  logic [OFFSET_BITS-1:0] hist_raddr;
  logic                   clen_we, ent_we;

  // shared datapath results
  logic              cur_bit;
  logic [CODE_W-1:0] partial_sh;
  logic [CLW-1:0]    pbits_inc;
  logic [FT-1:0]     mf_sh;
  logic              field_done;
  logic [OFFSET_BITS:0] off_calc;
  logic [LEN_W-1:0]  len_calc;
  logic              off_far, cap_hit;
  logic [CLW-1:0]    e_len;
  logic [CODE_W-1:0] e_code;
  logic [SYM_W-1:0]  e_sym;
  logic              lk_end, lk_break, lk_hit, lk_fail;
  logic [CODE_W-1:0] code_sh;
  logic              len_match, lanes_full;
  logic              accept, hdr_bad;
  logic              can_move, put_ok, put_req, drain, push_en;
  logic [7:0]        push_b;
  res_t              put_res, data_res, stat_res;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign cur_bit  = byte_r[bit_k];
  assign hdr_bad  = (hdr_idx < SYM_W'(MAGIC_LEN)) && (s_axis_tdata != head_byte(hdr_idx[2:0]));

  assign partial_sh = {partial[CODE_W-2:0], cur_bit};
  assign pbits_inc  = pbits + CLW'(1);
  assign mf_sh      = {mf[FT-2:0], cur_bit};
  assign field_done = (mfc + FCW'(1)) == FCW'(FT);
  assign off_calc   = {1'b0, mf_sh[FT-1:MATCH_LENGTH_BITS]} + (OFFSET_BITS+1)'(1);
  assign len_calc   = {2'b00, mf_sh[MATCH_LENGTH_BITS-1:0]} + LEN_W'(MATCH_BIAS);
  assign off_far    = CAP_W'(off_calc) > out_cnt;
  assign cap_hit    = out_cnt >= cap;
  assign hist_raddr = out_cnt[OFFSET_BITS-1:0] - off_r[OFFSET_BITS-1:0];

  // sorted table entry: code length, canonical code, symbol
  assign e_len    = ent_rdata[ENT_W-1 -: CLW];
  assign e_code   = ent_rdata[SYM_W +: CODE_W];
  assign e_sym    = ent_rdata[SYM_W-1:0];
  assign lk_end   = scan_idx >= used;
  assign lk_break = e_len > pbits;
  assign lk_hit   = (e_len == pbits) && (e_code == partial);
  // no code of this length: a full-length miss is a bad code
  assign lk_fail  = (state == ST_LK_RD && lk_end) || (state == ST_LK_CMP && lk_break);

  assign code_sh    = code << (blen - prev);
  assign len_match  = clen_rdata == 8'(blen);
  assign lanes_full = fill == LW'(OUTPUT_LANES - 1);

  assign ent_wdata = {blen, code_sh, bs};

  // a staged result can move on when the output register is free or being emptied
  assign can_move = !out_valid || m_axis_tready;
  assign put_ok   = !stg_v || can_move;

  // results built from the lane buffer and from the status register
  always_comb begin
    data_res        = '0;
    for (int i = 0; i < OUTPUT_LANES; i++) begin
      if (LW'(i) < fill) begin
        data_res.lanes[i] = lane_buf[i];
      end
    end
    data_res.count  = 4'(fill);
    data_res.status = STAT_DATA;
    data_res.total  = out_cnt;
    stat_res        = '0;
    stat_res.status = fin_status;
    stat_res.total  = out_cnt;
  end

  // next state
  always_comb begin
    state_next = state;
    ret_next   = ret_state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (phase)
            PH_HEADER: begin
              if (hdr_bad || s_axis_tlast) begin
                state_next = ST_FINISH;
              end else if (hdr_idx == SYM_W'(HEADER_LEN - 1)) begin
                state_next = ST_BD_RD;
              end
            end
            PH_SYMBOL, PH_MATCH: state_next = ST_BIT;
            default:             state_next = ST_IDLE;
          endcase
        end
      end
      ST_BD_RD:  state_next = ST_BD_CHK;
      ST_BD_CHK: begin
        if (bs == SYM_W'(NUM_SYMS - 1) && blen == CLW'(MAX_CODE_LENGTH)) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_BD_RD;
        end
      end
      ST_BIT: begin
        if (phase == PH_SYMBOL) begin
          state_next = ST_LK_RD;
        end else if (field_done) begin
          state_next = off_far ? ST_FINISH : ST_CP_RD;
        end else begin
          state_next = ST_NEXT;
        end
      end
      ST_LK_RD: begin
        if (lk_end) begin
          state_next = (pbits >= CLW'(MAX_CODE_LENGTH)) ? ST_FINISH : ST_NEXT;
        end else begin
          state_next = ST_LK_CMP;
        end
      end
      ST_LK_CMP: begin
        if (lk_break) begin
          state_next = (pbits >= CLW'(MAX_CODE_LENGTH)) ? ST_FINISH : ST_NEXT;
        end else if (lk_hit) begin
          if (e_sym < SYM_W'(SYM_END)) begin
            if (cap_hit) begin
              state_next = ST_FINISH;
            end else if (lanes_full) begin
              state_next = ST_EMIT;
              ret_next   = ST_NEXT;
            end else begin
              state_next = ST_NEXT;
            end
          end else if (e_sym == SYM_W'(SYM_END)) begin
            state_next = ST_FINISH;
          end else begin
            state_next = ST_NEXT;
          end
        end else begin
          state_next = ST_LK_RD;
        end
      end
      ST_CP_RD: state_next = cap_hit ? ST_FINISH : ST_CP_WR;
      ST_CP_WR: begin
        if (lanes_full) begin
          state_next = ST_EMIT;
          ret_next   = (left == LEN_W'(1)) ? ST_NEXT : ST_CP_RD;
        end else begin
          state_next = (left == LEN_W'(1)) ? ST_NEXT : ST_CP_RD;
        end
      end
      ST_EMIT: begin
        if (put_ok) begin
          state_next = ret_state;
        end
      end
      ST_NEXT: state_next = (bit_k == 3'd0) ? ST_ENDBYTE : ST_BIT;
      ST_ENDBYTE: begin
        if (fill != '0) begin
          state_next = ST_EMIT;
          ret_next   = ST_ENDBYTE;
        end else if (last_r) begin
          state_next = ST_FINISH;
        end else begin
          state_next = ST_END;
        end
      end
      ST_FINISH: begin
        if (fill != '0) begin
          state_next = ST_EMIT;
          ret_next   = ST_FINISH;
        end else if (put_ok) begin
          state_next = ST_END;
        end
      end
      ST_END: begin
        if (!stg_v || can_move) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    clen_we = 1'b0;
    ent_we  = 1'b0;
    push_en = 1'b0;
    push_b  = hist_rdata;
    put_req = 1'b0;
    put_res = data_res;
    drain   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        clen_we = accept && (phase == PH_HEADER) && (hdr_idx >= SYM_W'(MAGIC_LEN));
      end
      ST_BD_CHK: ent_we = len_match;
      ST_LK_CMP: begin
        push_en = !lk_break && lk_hit && (e_sym < SYM_W'(SYM_END)) && !cap_hit;
        push_b  = e_sym[7:0];
      end
      ST_CP_WR:  push_en = 1'b1;
      ST_EMIT:   put_req = 1'b1;
      ST_FINISH: begin
        put_req = (fill == '0);
        put_res = stat_res;
      end
      ST_END:    drain = stg_v && can_move;
      default: begin
        put_req = 1'b0;
      end
    endcase
  end

  // datapath and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      ret_state  <= ST_IDLE;
      phase      <= PH_HEADER;
      hdr_idx    <= '0;
      partial    <= '0;
      pbits      <= '0;
      scan_start <= '0;
      used       <= '0;
      mf         <= '0;
      mfc        <= '0;
      out_cnt    <= '0;
      cap        <= '1;
      fill       <= '0;
      stg_v      <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state     <= state_next;
      ret_state <= ret_next;
      if (cfg_we) begin
        cap <= cfg_wdata;
      end

      // output side: staging slot feeds the output register
      if (put_req && put_ok) begin
        stg   <= put_res;
        stg_v <= 1'b1;
        if (state == ST_EMIT) begin
          fill <= '0;
        end
      end
      if ((put_req && put_ok && stg_v) || drain) begin
        outr      <= stg;
        out_last  <= drain;
        out_valid <= 1'b1;
        if (drain) begin
          stg_v <= 1'b0;
        end
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end

      // decoded byte into history and lanes
      if (push_en) begin
        out_cnt <= out_cnt + CAP_W'(1);
        fill    <= fill + LW'(1);
        for (int i = 0; i < OUTPUT_LANES; i++) begin
          if (fill == LW'(i)) begin
            lane_buf[i] <= push_b;
          end
        end
      end

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            byte_r <= s_axis_tdata;
            last_r <= s_axis_tlast;
            bit_k  <= 3'd7;
            if (phase == PH_HEADER) begin
              if (hdr_bad) begin
                fin_status <= STAT_BAD_HEADER;
              end else begin
                hdr_idx <= hdr_idx + SYM_W'(1);
                if (s_axis_tlast) begin
                  fin_status <= STAT_TRUNCATED;
                end
              end
              bs   <= '0;
              blen <= CLW'(1);
              prev <= '0;
              code <= '0;
              used <= '0;
            end
          end
        end
        ST_BD_CHK: begin
          if (len_match) begin
            used <= used + SYM_W'(1);
            code <= code_sh + CODE_W'(1);
            prev <= blen;
          end
          if (bs == SYM_W'(NUM_SYMS - 1)) begin
            bs   <= '0;
            blen <= blen + CLW'(1);
            if (blen == CLW'(MAX_CODE_LENGTH)) begin
              phase      <= PH_SYMBOL;
              scan_start <= '0;
              partial    <= '0;
              pbits      <= '0;
            end
          end else begin
            bs <= bs + SYM_W'(1);
          end
        end
        ST_BIT: begin
          if (phase == PH_SYMBOL) begin
            partial  <= partial_sh;
            pbits    <= pbits_inc;
            scan_idx <= scan_start;
          end else begin
            if (field_done) begin
              phase <= PH_SYMBOL;
              mf    <= '0;
              mfc   <= '0;
              off_r <= off_calc;
              left  <= len_calc;
              if (off_far) begin
                fin_status <= STAT_OFFSET;
              end
            end else begin
              mf  <= mf_sh;
              mfc <= mfc + FCW'(1);
            end
          end
        end
        ST_LK_RD, ST_LK_CMP: begin
          if (lk_fail) begin
            scan_start <= scan_idx;
            fin_status <= STAT_BAD_CODE;
          end else if (state == ST_LK_CMP) begin
            if (lk_hit) begin
              partial    <= '0;
              pbits      <= '0;
              scan_start <= '0;
              if (e_sym < SYM_W'(SYM_END)) begin
                fin_status <= STAT_CAPACITY;
              end else if (e_sym == SYM_W'(SYM_END)) begin
                fin_status <= STAT_DONE;
              end else begin
                phase <= PH_MATCH;
                mf    <= '0;
                mfc   <= '0;
              end
            end else begin
              scan_idx <= scan_idx + SYM_W'(1);
            end
          end
        end
        ST_CP_RD: fin_status <= STAT_CAPACITY;
        ST_CP_WR: left <= left - LEN_W'(1);
        ST_NEXT:  bit_k <= bit_k - 3'd1;
        ST_ENDBYTE: fin_status <= STAT_TRUNCATED;
        ST_FINISH: begin
          if (put_req && put_ok) begin
            phase <= PH_TERMINAL;
          end
        end
        default: ;
      endcase
    end
  end

  // code lengths as they arrive in the header
  hlz_ram #(.WIDTH(8), .DEPTH(NUM_SYMS)) u_clen (
    .clk   (clk),
    .we    (clen_we),
    .waddr (hdr_idx - SYM_W'(MAGIC_LEN)),
    .wdata (s_axis_tdata),
    .raddr (bs),
    .rdata (clen_rdata)
  );

  // canonical code table, sorted by length then symbol
  hlz_ram #(.WIDTH(ENT_W), .DEPTH(NUM_SYMS)) u_codes (
    .clk   (clk),
    .we    (ent_we),
    .waddr (used),
    .wdata (ent_wdata),
    .raddr (scan_idx),
    .rdata (ent_rdata)
  );

  // history window for match copies
  hlz_ram #(.WIDTH(8), .DEPTH(HIST_DEPTH)) u_hist (
    .clk   (clk),
    .we    (push_en),
    .waddr (out_cnt[OFFSET_BITS-1:0]),
    .wdata (push_b),
    .raddr (hist_raddr),
    .rdata (hist_rdata)
  );

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'b0000, outr.total, outr.count, outr.lanes};
  assign m_axis_tuser  = outr.status;
  assign m_axis_tlast  = out_last;

  // the staging slot is always empty between input bytes
  a_idle_drained: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !stg_v)
    else $error("staged result left over while taking input");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= LW'(OUTPUT_LANES))
    else $error("lane fill beyond lane count");

  a_terminal_sticks: assert property (@(posedge clk) disable iff (rst)
    phase == PH_TERMINAL |=> phase == PH_TERMINAL)
    else $error("left terminal phase without reset");

  a_status_no_bytes: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser != STAT_DATA) |->
      m_axis_tdata[TD_TOTAL_LO-1:TD_COUNT_LO] == 4'd0)
    else $error("status result carries bytes");

endmodule

// ----- hw/rtl/hlz_ram.sv -----
// generic simple dual-port ram with registered read
module hlz_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- tb/tb_huffman_lz_stream_decompressor.sv -----
// self-checking testbench of the huffman/lz stream decompressor
module tb_huffman_lz_stream_decompressor;
  import hlz_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int OFF_BITS   = 12;
  localparam int LEN_BITS   = 8;
  localparam int CODE_MAX   = 16;
  localparam int HIST_DEPTH = 1 << OFF_BITS;
  localparam int SYM_MATCH  = 257;
  localparam int RANDOM_BYTES = 200;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int SETTLE_CYCLES = 12000;

  // one decoded output transfer as the block should present it
  typedef struct {
    logic [63:0] lanes;
    logic [3:0]  count;
    status_t     st;
    logic [31:0] total;
    bit          lastr;
  } lane_word_t;

  typedef struct {
    logic [7:0] data;
    bit         lastf;
  } comp_byte_t;

  // how the generated stream is made to end
  typedef enum int {END_DONE, END_TRUNC, END_BADCODE, END_OFFSET, END_CAPACITY} ending_t;

  // decoder model plus the queue of transfers it still owes
  class lz_scoreboard;
    logic [31:0] cap;
    phase_t      ph;
    int          hidx;
    logic [7:0]  lens[NUM_SYMS];
    int          srt[NUM_SYMS];
    logic [15:0] cds[NUM_SYMS];
    logic [15:0] code_of[NUM_SYMS];
    int          used;
    logic [15:0] pc;
    int          pcb;
    logic [19:0] mfb;
    int          mfc;
    logic [31:0] cnt;
    logic [7:0]  hist[HIST_DEPTH];
    logic [7:0]  lbuf[8];
    int          fill;
    lane_word_t  due_q[$];
    int          errors;
    int          seen;
    status_t     term_st;

    function new();
      cap = '1;
      ph = PH_HEADER;
      hidx = 0;
      used = 0;
      pc = 0;
      pcb = 0;
      mfb = 0;
      mfc = 0;
      cnt = 0;
      fill = 0;
      errors = 0;
      seen = 0;
      term_st = STAT_DATA;
    endfunction

    function void emit(status_t st, int n);
      lane_word_t w;
      w.lanes = '0;
      for (int i = 0; i < n; i++) w.lanes[8*i +: 8] = lbuf[i];
      w.count = 4'(n);
      w.st = st;
      w.total = cnt;
      w.lastr = 0;
      due_q.push_back(w);
    endfunction

    function void flush();
      if (fill > 0) emit(STAT_DATA, fill);
      fill = 0;
    endfunction

    function void finish_with(status_t st);
      flush();
      emit(st, 0);
      ph = PH_TERMINAL;
    endfunction

    function void push_out(logic [7:0] b);
      hist[cnt[OFF_BITS-1:0]] = b;
      cnt++;
      lbuf[fill] = b;
      fill++;
      if (fill == 8) flush();
    endfunction

    // canonical code: ordered by length, then by symbol, modulo 2^16
    function void build_codes();
      logic [31:0] c;
      int prev;
      c = 0;
      prev = 0;
      used = 0;
      for (int l = 1; l <= CODE_MAX; l++) begin
        for (int s = 0; s < NUM_SYMS; s++) begin
          if (lens[s] != l) continue;
          c = (c << (l - prev)) & 32'hFFFF;
          srt[used] = s;
          cds[used] = c[15:0];
          code_of[s] = c[15:0];
          used++;
          c = (c + 1) & 32'hFFFF;
          prev = l;
        end
      end
    endfunction

    // first match in sorted order wins, so duplicate codes resolve the same way
    function int find_sym(logic [15:0] c, int l);
      for (int i = 0; i < used; i++) begin
        if (lens[srt[i]] > l) break;
        if (lens[srt[i]] == l && cds[i] == c) return srt[i];
      end
      return -1;
    endfunction

    function void take_bit(logic b);
      int sym;
      logic [31:0] off;
      logic [31:0] mlen;
      if (ph == PH_SYMBOL) begin
        pc = {pc[14:0], b};
        pcb++;
        sym = find_sym(pc, pcb);
        if (sym < 0) begin
          if (pcb >= CODE_MAX) finish_with(STAT_BAD_CODE);
          return;
        end
        pc = 0;
        pcb = 0;
        if (sym < SYM_END) begin
          if (cnt >= cap) finish_with(STAT_CAPACITY);
          else push_out(sym[7:0]);
        end else if (sym == SYM_END) begin
          finish_with(STAT_DONE);
        end else begin
          ph = PH_MATCH;
          mfb = 0;
          mfc = 0;
        end
      end else if (ph == PH_MATCH) begin
        mfb = {mfb[18:0], b};
        mfc++;
        if (mfc >= OFF_BITS + LEN_BITS) begin
          off = (mfb >> LEN_BITS) + 1;
          mlen = mfb[LEN_BITS-1:0] + MATCH_BIAS;
          ph = PH_SYMBOL;
          mfb = 0;
          mfc = 0;
          if (off > cnt) begin
            finish_with(STAT_OFFSET);
            return;
          end
          for (int i = 0; i < mlen; i++) begin
            if (cnt >= cap) begin
              finish_with(STAT_CAPACITY);
              return;
            end
            push_out(hist[(cnt - off) & (HIST_DEPTH - 1)]);
          end
        end
      end
    endfunction

    // one accepted compressed byte
    function void note_byte(logic [7:0] b, bit lastf);
      int q_start;
      lane_word_t w;
      logic [7:0] magic[6];
      magic = '{8'h54, 8'h43, 8'h46, 8'h31, 8'h02, 8'h01};
      q_start = due_q.size();
      fill = 0;
      if (ph == PH_TERMINAL) return;
      if (ph == PH_HEADER) begin
        if (hidx < 6) begin
          if (b != magic[hidx]) finish_with(STAT_BAD_HEADER);
        end else begin
          lens[hidx - 6] = b;
        end
        if (ph == PH_HEADER) begin
          hidx++;
          if (hidx >= HEADER_LEN) begin
            build_codes();
            ph = PH_SYMBOL;
          end
        end
      end else begin
        for (int k = 7; k >= 0 && ph != PH_TERMINAL; k--) take_bit(b[k]);
      end
      if (ph != PH_TERMINAL) begin
        flush();
        if (lastf) finish_with(STAT_TRUNCATED);
      end
      if (due_q.size() > q_start) begin
        w = due_q.pop_back();
        w.lastr = 1;
        due_q.push_back(w);
      end
    endfunction

    function void check_word(logic [TD_W-1:0] td, logic [2:0] tu, logic tl);
      lane_word_t w;
      if (due_q.size() == 0) begin
        $display("%0t: unexpected output transfer tdata=%h tuser=%0d", $time, td, tu);
        errors++;
        return;
      end
      w = due_q.pop_front();
      seen++;
      if (td[63:0] !== w.lanes) begin
        $display("%0t: lanes exp %h got %h", $time, w.lanes, td[63:0]);
        errors++;
      end
      if (td[TD_COUNT_LO +: 4] !== w.count) begin
        $display("%0t: byte_count exp %0d got %0d", $time, w.count, td[TD_COUNT_LO +: 4]);
        errors++;
      end
      if (tu !== w.st) begin
        $display("%0t: status exp %0d got %0d", $time, w.st, tu);
        errors++;
      end
      if (td[TD_TOTAL_LO +: 32] !== w.total) begin
        $display("%0t: total_length exp %0d got %0d", $time, w.total, td[TD_TOTAL_LO +: 32]);
        errors++;
      end
      if (tl !== w.lastr) begin
        $display("%0t: last_of_run exp %0d got %0d", $time, w.lastr, tl);
        errors++;
      end
      if (w.count == 0) term_st = w.st;
    endfunction
  endclass

  logic            clk;
  logic            rst;
  logic            cfg_we;
  logic [31:0]     cfg_wdata;
  logic            s_axis_tvalid;
  logic            s_axis_tready;
  logic [7:0]      s_axis_tdata;   // in_byte
  logic            s_axis_tlast;   // last_byte
  logic            m_axis_tvalid;
  logic            m_axis_tready;
  logic [TD_W-1:0] m_axis_tdata;   // lane0..lane7, byte_count, total_length
  logic [2:0]      m_axis_tuser;   // status
  logic            m_axis_tlast;   // last_of_run

  huffman_lz_stream_decompressor u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  lz_scoreboard decoder_sb;
  lz_scoreboard code_book;   // same model, used only to learn the codes for encoding
  comp_byte_t   comp_q[$];
  bit           bit_q[$];
  int           lit_pool[$];
  int           gen_count;
  int           pause_a;
  int           pause_b;
  ending_t      ending;
  int           cycles;
  bit           calm_in;
  bit           calm_out;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // watchdog
  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  // output side: sample every accepted transfer at the rising edge
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      decoder_sb.check_word(m_axis_tdata, m_axis_tuser, m_axis_tlast);
  end

  // output back-pressure: a random wait before each transfer,
  // with calm stretches where ready stays high
  initial begin
    int k;
    m_axis_tready = 0;
    calm_out = 0;
    forever begin
      if ($urandom_range(0, 15) == 0) calm_out = !calm_out;
      k = calm_out ? 0 : $urandom_range(0, 3);
      if (k > 0) begin
        @(negedge clk);
        m_axis_tready <= 0;
        repeat (k) @(negedge clk);
      end else begin
        @(negedge clk);
      end
      m_axis_tready <= 1;
      do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  // ---------- stream generation ----------

  task automatic put_bits(input logic [31:0] v, input int n);
    for (int i = n - 1; i >= 0; i--) bit_q.push_back(v[i]);
  endtask

  task automatic put_sym(input int s);
    put_bits(code_book.code_of[s], code_book.lens[s]);
  endtask

  task automatic put_lit(input int s);
    put_sym(s);
    gen_count++;
  endtask

  // offset and length as the block sees them: fields hold offset-1 and length-3
  task automatic put_match(input int off, input int mlen);
    put_sym(SYM_MATCH);
    put_bits(off - 1, OFF_BITS);
    put_bits(mlen - MATCH_BIAS, LEN_BITS);
    gen_count += mlen;
  endtask

  task automatic put_random_symbol();
    int lim;
    if (gen_count == 0 || $urandom_range(0, 9) < 7) begin
      put_lit(lit_pool[$urandom_range(0, lit_pool.size() - 1)]);
    end else begin
      lim = (gen_count < HIST_DEPTH) ? gen_count : HIST_DEPTH;
      // mostly short copies so the run stays short, now and then the longest
      put_match($urandom_range(1, lim),
                ($urandom_range(0, 9) == 0) ? 258 : $urandom_range(3, 24));
    end
  endtask

  task automatic make_stream();
    logic [7:0] hdr[HEADER_LEN];
    comp_byte_t it;
    int dir_bits;
    logic [7:0] v;
    hdr[0] = 8'h54; hdr[1] = 8'h43; hdr[2] = 8'h46; hdr[3] = 8'h31;
    hdr[4] = 8'h02; hdr[5] = 8'h01;
    // most literals take 10 bits; a few short ones, some symbols left out
    // by a zero length or a length beyond the code limit
    for (int s = 0; s < NUM_SYMS; s++) hdr[6 + s] = 8'd10;
    hdr[6 + 0] = 8'd4;
    hdr[6 + 255] = 8'd4;
    for (int i = 0; i < 6; i++) hdr[6 + $urandom_range(5, 254)] = 8'd4;
    hdr[6 + 1] = 8'd0;
    hdr[6 + 2] = 8'd0;
    hdr[6 + 3] = 8'd17;
    hdr[6 + 4] = 8'd255;
    hdr[6 + SYM_END] = 8'd16;
    hdr[6 + SYM_MATCH] = 8'd2;
    for (int i = 0; i < HEADER_LEN; i++) begin
      it.data = hdr[i];
      it.lastf = 0;
      comp_q.push_back(it);
      code_book.note_byte(hdr[i], 0);
    end
    for (int s = 0; s < SYM_END; s++)
      if (hdr[6 + s] >= 1 && hdr[6 + s] <= CODE_MAX) lit_pool.push_back(s);

    // directed part: literal extremes, overlapping copies, the longest copy,
    // an offset reaching back to the very first byte, a full lane run
    gen_count = 0;
    put_lit(0);
    put_lit(255);
    put_lit(65);
    put_match(1, 3);
    put_match(1, 258);
    put_match(gen_count, 5);
    for (int i = 0; i < 10; i++) put_lit(lit_pool[$urandom_range(0, lit_pool.size() - 1)]);
    put_match(2, 17);
    put_match(7, 9);
    dir_bits = bit_q.size();
    pause_a = HEADER_LEN + dir_bits / 8;

    while (bit_q.size() < dir_bits + 8 * RANDOM_BYTES) put_random_symbol();
    pause_b = HEADER_LEN + bit_q.size() / 8 - 2;

    case (ending)
      END_DONE: put_sym(SYM_END);
      END_TRUNC: put_lit(lit_pool[0]);
      END_BADCODE: put_bits(32'hFFFF, 16);
      END_OFFSET: begin
        put_sym(SYM_MATCH);
        put_bits(HIST_DEPTH - 1, OFF_BITS);
        put_bits($urandom_range(0, 255), LEN_BITS);
      end
      default: begin
        for (int i = 0; i < 40; i++) put_random_symbol();
        put_sym(SYM_END);
      end
    endcase

    // pack MSB first, pad with random bits, mark the final byte
    while (bit_q.size() > 0) begin
      v = 0;
      for (int i = 0; i < 8; i++)
        v = {v[6:0], (bit_q.size() > 0) ? bit_q.pop_front() : 1'($urandom_range(0, 1))};
      it.data = v;
      it.lastf = (bit_q.size() == 0);
      comp_q.push_back(it);
    end
  endtask

  // ---------- drivers ----------

  task automatic cfg_write(input logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1;
    cfg_wdata <= val;
    @(posedge clk);
    decoder_sb.cap = val;
    @(negedge clk);
    cfg_we <= 0;
  endtask

  // one transfer per byte, with random gaps between them
  task automatic send_range(input int from, input int upto);
    int gap;
    for (int i = from; i < upto; i++) begin
      if ($urandom_range(0, 15) == 0) calm_in = !calm_in;
      gap = calm_in ? 0 : $urandom_range(0, 3);
      @(negedge clk);
      if (gap > 0) begin
        s_axis_tvalid <= 0;
        repeat (gap) @(negedge clk);
      end
      s_axis_tvalid <= 1;
      s_axis_tdata <= comp_q[i].data;
      s_axis_tlast <= comp_q[i].lastf;
      do @(posedge clk); while (!s_axis_tready);
      decoder_sb.note_byte(comp_q[i].data, comp_q[i].lastf);
    end
    @(negedge clk);
    s_axis_tvalid <= 0;
  endtask

  // hold off until every owed transfer has come, then let the block settle
  task automatic drain_and_settle(input int settle);
    while (decoder_sb.due_q.size() > 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  initial begin
    decoder_sb = new();
    code_book = new();
    calm_in = 0;
    rst = 1;
    cfg_we = 0;
    cfg_wdata = 0;
    s_axis_tvalid = 0;
    s_axis_tdata = 0;
    s_axis_tlast = 0;
    ending = ending_t'($urandom_range(0, 4));
    make_stream();

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    cfg_write(32'hFFFF_FFFF);
    // header and directed bitstream, then a full pause
    send_range(0, pause_a);
    drain_and_settle(SETTLE_CYCLES);
    cfg_write(decoder_sb.cnt + 32'h0100_0000);
    send_range(pause_a, pause_b);
    drain_and_settle(SETTLE_CYCLES);
    // capacity ending: leave room for only a handful more bytes
    if (ending == END_CAPACITY)
      cfg_write(decoder_sb.cnt + $urandom_range(0, 30));
    else
      cfg_write(decoder_sb.cnt + $urandom_range(1000, 100000));
    send_range(pause_b, comp_q.size());
    drain_and_settle(2000);
    cfg_write(32'h0000_0000);
    repeat (20) @(posedge clk);

    $display("covered %0d compressed bytes and %0d output transfers, %0d bytes decoded",
             comp_q.size(), decoder_sb.seen, decoder_sb.cnt);
    $display("stream ending %s, final status %0d", ending.name(), decoder_sb.term_st);
    if (decoder_sb.errors == 0 && decoder_sb.due_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
